FILE: src/fsq_pkg.sv
// ---------------------------------------------------------------------------
// fsq_pkg: shared types and codes for the request queue
// Status codes, request kinds, register indexes and the slot entry layout.
// ---------------------------------------------------------------------------
package fsq_pkg;

  localparam int CONN_W     = 16;
  localparam int SIZE_W     = 32;
  localparam int OCC_W      = 5;
  localparam int CAP_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_FULL   = 2'd1,
    ST_POPPED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Request kinds
  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd1;

  // One queue slot
  typedef struct packed {
    logic [CONN_W-1:0] conn;
    logic [SIZE_W-1:0] size;
  } slot_t;

endpackage

FILE: src/fsq_if.sv
// ---------------------------------------------------------------------------
// fsq_req_if / fsq_rsp_if: request and result channels
// Valid/ready handshake; a transfer happens when valid and ready are high.
// ---------------------------------------------------------------------------
interface fsq_req_if import fsq_pkg::*;;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [CONN_W-1:0]   conn_id;
  logic [SIZE_W-1:0]   req_size;

  modport source (output valid, kind, conn_id, req_size, input ready);
  modport sink   (input valid, kind, conn_id, req_size, output ready);
endinterface

interface fsq_rsp_if import fsq_pkg::*;;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [CONN_W-1:0]   out_conn_id;
  logic [SIZE_W-1:0]   out_req_size;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, status, out_conn_id, out_req_size, occupancy,
                  input ready);
  modport sink   (input valid, status, out_conn_id, out_req_size, occupancy,
                  output ready);
endinterface

FILE: src/fifo_or_smallest_first_request_queue.sv
// ---------------------------------------------------------------------------
// fifo_or_smallest_first_request_queue: bounded request queue
// Holds connection requests in arrival order; pops oldest or smallest first.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one request: a push (conn_id, req_size) or a pop.
//   out_ch returns exactly one result per request: status, popped entry
//   (zero unless popped) and occupancy after the request.
//   cfg_we/cfg_idx/cfg_wdata write policy_mode (0 oldest, 1 smallest size)
//   and queue_capacity; write them only while the queue is idle.
// Operation:
//   A push or a refused pop is answered straight from the idle state. A pop
//   reads the slot RAM through its single read port, one slot per cycle, into
//   one comparator (all held slots in smallest-first mode, slot 0 only in
//   oldest-first mode), then closes the gap by moving later slots down one
//   per cycle. One request is in flight at a time; in_ch.ready is low
//   meanwhile.
// Reset: queue empty, policy oldest-first, capacity 1. Slots need no clear.
// Stall: a result waits in the output register; a new request is taken
//   when that register is empty or is being drained in the same cycle.
// ---------------------------------------------------------------------------
module fifo_or_smallest_first_request_queue import fsq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  fsq_req_if.sink               in_ch,
  fsq_rsp_if.source             out_ch
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t              state_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic                policy_r;
  logic [CAP_W-1:0]    cap_r;
  logic [CW-1:0]       ptr_r;
  logic [CW-1:0]       end_r;
  logic                rd_vld_r;
  logic [AW-1:0]       rd_idx_r;
  slot_t               best_r;
  logic [AW-1:0]       best_idx_r;
  slot_t               rd_data;

  logic                out_v_r;
  status_t             out_status_r, out_status_nxt;
  logic [CONN_W-1:0]   out_conn_r, out_conn_nxt;
  logic [SIZE_W-1:0]   out_size_r, out_size_nxt;
  logic [OCC_W-1:0]    out_occ_r;
  logic                out_load;

  logic                in_fire;
  logic                is_push;
  logic                full;
  logic                issue;
  logic                drain;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  slot_t               wr_data;
  logic [CMPW-1:0]     cap_ext, eff_cap;

  // handshake
  assign in_ch.ready = (state_r == S_IDLE) && (!out_v_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_push     = (in_ch.kind == KIND_PUSH);

  // effective capacity saturates at DEPTH
  assign cap_ext = CMPW'(cap_r);
  assign eff_cap = (cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_ext;
  assign full    = (CMPW'(count_r) >= eff_cap);

  // read sequencing shared by scan and shift
  assign issue = ((state_r == S_SCAN) || (state_r == S_SHIFT)) && (ptr_r < end_r);
  assign drain = !issue && !rd_vld_r;

  // slot write port: push appends, shift moves an entry down one
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = '{conn: in_ch.conn_id, size: in_ch.req_size};
    if (state_r == S_SHIFT) begin
      wr_en   = rd_vld_r;
      wr_addr = rd_idx_r - AW'(1);
      wr_data = rd_data;
    end else if (in_fire && is_push && !full) begin
      wr_en = 1'b1;
    end
  end

  fsq_slot_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (ptr_r[AW-1:0]),
    .rdata (rd_data)
  );

  // result and count update
  always_comb begin
    count_nxt      = count_r;
    out_load       = 1'b0;
    out_status_nxt = ST_POPPED;
    out_conn_nxt   = '0;
    out_size_nxt   = '0;
    if (in_fire) begin
      if (is_push) begin
        out_load       = 1'b1;
        out_status_nxt = full ? ST_FULL : ST_PUSHED;
        if (!full) begin
          count_nxt = count_r + CW'(1);
        end
      end else if (count_r == '0) begin
        out_load       = 1'b1;
        out_status_nxt = ST_EMPTY;
      end
    end else if ((state_r == S_SHIFT) && drain) begin
      out_load       = 1'b1;
      out_status_nxt = ST_POPPED;
      out_conn_nxt   = best_r.conn;
      out_size_nxt   = best_r.size;
      count_nxt      = count_r - CW'(1);
    end
  end

  // control registers and sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      policy_r <= 1'b0;
      cap_r    <= CAP_W'(1);
      rd_vld_r <= 1'b0;
      out_v_r  <= 1'b0;
      ptr_r    <= '0;
      end_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_POLICY:   policy_r <= cfg_wdata[0];
          REG_CAPACITY: cap_r    <= cfg_wdata[CAP_W-1:0];
          default: ;
        endcase
      end
      rd_vld_r <= issue;
      count_r  <= count_nxt;
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && !is_push && (count_r != '0)) begin
            state_r <= S_SCAN;
            ptr_r   <= '0;
            end_r   <= policy_r ? count_r : CW'(1);
          end
        end
        S_SCAN: begin
          if (issue) begin
            ptr_r <= ptr_r + CW'(1);
          end else if (drain) begin
            state_r <= S_SHIFT;
            ptr_r   <= CW'(best_idx_r) + CW'(1);
            end_r   <= count_r;
          end
        end
        S_SHIFT: begin
          if (issue) begin
            ptr_r <= ptr_r + CW'(1);
          end else if (drain) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // shared comparator: keep the first strictly smallest entry seen
  always_ff @(posedge clk) begin
    if ((state_r == S_SCAN) && rd_vld_r) begin
      if ((rd_idx_r == '0) || (rd_data.size < best_r.size)) begin
        best_r     <= rd_data;
        best_idx_r <= rd_idx_r;
      end
    end
    if (issue) begin
      rd_idx_r <= ptr_r[AW-1:0];
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_conn_r   <= out_conn_nxt;
      out_size_r   <= out_size_nxt;
      out_occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.out_conn_id  = out_conn_r;
  assign out_ch.out_req_size = out_size_r;
  assign out_ch.occupancy    = out_occ_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("held count above depth");

  a_shift_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && wr_en) |-> (CW'(wr_addr) < count_r))
    else $error("shift write beyond held entries");

  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_v_r)
    else $error("result pending while a pop is in progress");

  // only after a compare past slot 0, when best already holds a real entry
  a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && $past(state_r) == S_SCAN &&
     $past(rd_vld_r) && $past(rd_idx_r) != '0)
    |-> (best_r.size <= $past(best_r.size)))
    else $error("best size grew during scan");

endmodule

FILE: src/fsq_slot_ram.sv
// ---------------------------------------------------------------------------
// fsq_slot_ram: slot storage
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module fsq_slot_ram import fsq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  slot_t         wdata,
  input  logic [AW-1:0] raddr,
  output slot_t         rdata
);

  slot_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: tb/fifo_or_smallest_first_request_queue_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fifo_or_smallest_first_request_queue_test: request queue testbench
// Sends push and pop requests under oldest-first and smallest-first policies
// and several capacities. Each request is run through a queue model when the
// block takes it. Each result is checked in order against that model, with
// random idling on both channels and a long output stall.
// ---------------------------------------------------------------------------
module fifo_or_smallest_first_request_queue_test;
  import fsq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int MAX_WAIT     = 13;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int FLUSH_CYCLES = 2 * DEPTH + 8;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    status_t           status;
    logic [CONN_W-1:0] conn;
    logic [SIZE_W-1:0] size;
    logic [OCC_W-1:0]  occ;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fsq_req_if req_ch ();
  fsq_rsp_if rsp_ch ();

  fifo_or_smallest_first_request_queue #(
    .DEPTH (DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch)
  );

  // Queue model state and expected results
  slot_t            held_slots[$];
  logic             policy_smallest;
  logic [CAP_W-1:0] capacity;
  result_t          pending_results[$];
  int               mismatch_count = 0;

  // Idling controls for the request sender and the result sink
  bit tx_idle;
  bit rx_idle;
  int hold_request;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Queue model: apply one request and return its result
  function automatic result_t serve_request(kind_t kind, logic [CONN_W-1:0] conn,
                                            logic [SIZE_W-1:0] size);
    result_t r;
    int      pick;
    int      room;
    slot_t   s;
    r      = '0;
    room   = (capacity > DEPTH) ? DEPTH : int'(capacity);
    if (kind == KIND_PUSH) begin
      if (held_slots.size() >= room) begin
        r.status = ST_FULL;
      end else begin
        s.conn = conn;
        s.size = size;
        held_slots.push_back(s);
        r.status = ST_PUSHED;
      end
    end else if (held_slots.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      pick = 0;
      // smallest size wins; strict compare keeps the oldest on a tie
      if (policy_smallest) begin
        for (int i = 1; i < held_slots.size(); i++) begin
          if (held_slots[i].size < held_slots[pick].size) pick = i;
        end
      end
      r.conn   = held_slots[pick].conn;
      r.size   = held_slots[pick].size;
      r.status = ST_POPPED;
      held_slots.delete(pick);
    end
    r.occ = OCC_W'(held_slots.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [SIZE_W-1:0] got,
                                 logic [SIZE_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Offer one request after a random gap; model it once it is taken
  task automatic send_request(kind_t kind, logic [CONN_W-1:0] conn,
                              logic [SIZE_W-1:0] size);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.kind     <= kind;
    req_ch.conn_id  <= conn;
    req_ch.req_size <= size;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.push_back(serve_request(kind, conn, size));
  endtask

  task automatic random_request(int push_pct);
    kind_t             kind;
    logic [SIZE_W-1:0] size;
    kind = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
    // small sizes make ties likely under smallest-first
    case ($urandom_range(0, 3))
      0: begin
        size = $urandom_range(0, 7);
      end
      1: begin
        size = $urandom_range(0, 1) ? '1 : '0;
      end
      default: begin
        size = $urandom;
      end
    endcase
    send_request(kind, CONN_W'($urandom), size);
  endtask

  // Stop offering and wait until every result is back
  task automatic wait_drained(int settle);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_POLICY) policy_smallest = data[0];
    else capacity = data[CAP_W-1:0];
    @(posedge clk);
  endtask

  // Upper policy bits are don't-care, so fill them at random
  task automatic set_config(logic smallest, logic [CAP_W-1:0] cap);
    logic [CFG_DATA_W-1:0] pol_word;
    pol_word    = CFG_DATA_W'($urandom);
    pol_word[0] = smallest;
    write_reg(REG_POLICY, pol_word);
    write_reg(REG_CAPACITY, cap);
  endtask

  // Reset defaults: oldest first, room for one request
  task automatic test_reset_state();
    send_request(KIND_POP, '1, '1);
    send_request(KIND_PUSH, 16'h0001, 32'h0000_0010);
    send_request(KIND_PUSH, 16'h0002, 32'h0000_0001);
    send_request(KIND_POP, '0, '0);
    wait_drained(4);
  endtask

  // Zero capacity refuses every push
  task automatic test_zero_capacity();
    set_config(1'b0, 5'd0);
    send_request(KIND_PUSH, '1, '1);
    send_request(KIND_POP, 16'h5a5a, 32'ha5a5_a5a5);
    wait_drained(4);
  endtask

  // Smallest first with a tie and both size extremes
  task automatic test_smallest_first_ties();
    set_config(1'b1, 5'd4);
    send_request(KIND_PUSH, 16'hffff, 32'hffff_ffff);
    send_request(KIND_PUSH, 16'h0000, 32'h0000_0003);
    send_request(KIND_PUSH, 16'h1234, 32'h0000_0003);
    send_request(KIND_PUSH, 16'haaaa, 32'h0000_0000);
    send_request(KIND_PUSH, 16'h5555, 32'h0000_0000);
    repeat (5) send_request(KIND_POP, '0, '0);
    wait_drained(4);
  endtask

  // Capacity cut below occupancy: pushes refused until pops catch up
  task automatic test_capacity_lowered();
    set_config(1'b0, 5'd3);
    send_request(KIND_PUSH, 16'h0011, 32'h0000_0100);
    send_request(KIND_PUSH, 16'h0022, 32'h0000_0200);
    send_request(KIND_PUSH, 16'h0033, 32'h0000_0300);
    wait_drained(4);
    write_reg(REG_CAPACITY, 5'd1);
    send_request(KIND_PUSH, 16'h0044, 32'h0000_0400);
    send_request(KIND_POP, '0, '0);
    send_request(KIND_POP, '0, '0);
    send_request(KIND_PUSH, 16'h0055, 32'h0000_0500);
    send_request(KIND_POP, '0, '0);
    send_request(KIND_PUSH, 16'h0066, 32'h0000_0600);
    wait_drained(4);
  endtask

  // One random phase: a push-heavy half to fill, a pop-heavy half to drain
  task automatic run_random_phase(logic smallest, logic [CAP_W-1:0] cap, bit tx, bit rx,
                                  int n_items, int fill_pct);
    wait_drained(4);
    set_config(smallest, cap);
    tx_idle = tx;
    rx_idle = rx;
    for (int i = 0; i < n_items; i++)
      random_request((i < n_items / 2) ? fill_pct : 100 - fill_pct);
  endtask

  task automatic test_random_traffic();
    run_random_phase(1'b0, 5'd16, 1'b1, 1'b1, 60, 75);
    run_random_phase(1'b1, 5'd16, 1'b0, 1'b0, 60, 75);
    run_random_phase(1'b1, 5'd31, 1'b1, 1'b0, 60, 85);
    run_random_phase(1'b0, 5'd0, 1'b1, 1'b1, 20, 50);
    run_random_phase(1'b1, 5'd1, 1'b0, 1'b1, 40, 50);
    run_random_phase(1'b0, CAP_W'($urandom_range(2, 15)), 1'b1, 1'b1, 60, 70);
    run_random_phase(1'b1, CAP_W'($urandom_range(1, 31)), 1'b1, 1'b1, 60, 75);
    run_random_phase(1'b1, 5'd16, 1'b1, 1'b1, 60, 80);
    wait_drained(4);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Result side holds off while requests keep coming
  task automatic test_output_backpressure();
    set_config(1'b1, 5'd8);
    tx_idle      = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (24) random_request(60);
    wait_drained(4);
    tx_idle = 1'b1;
  endtask

  // Result sink: random stall before each result, long hold on request
  initial begin : result_sink
    int wait_n;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        wait_n       = hold_request;
        hold_request = 0;
      end else begin
        wait_n = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
      end
      if (wait_n > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  // Compare each returned result with the oldest expected one
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", SIZE_W'(rsp_ch.status), '0);
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", SIZE_W'(rsp_ch.status), SIZE_W'(want.status));
        if (rsp_ch.out_conn_id !== want.conn)
          report_mismatch("conn_id", SIZE_W'(rsp_ch.out_conn_id), SIZE_W'(want.conn));
        if (rsp_ch.out_req_size !== want.size)
          report_mismatch("size", rsp_ch.out_req_size, want.size);
        if (rsp_ch.occupancy !== want.occ)
          report_mismatch("occupancy", SIZE_W'(rsp_ch.occupancy), SIZE_W'(want.occ));
      end
    end
  end

  // Watchdog: too long with no handshake on either channel
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= '0;
    cfg_wdata       <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.kind     <= KIND_PUSH;
    req_ch.conn_id  <= '0;
    req_ch.req_size <= '0;
    held_slots.delete();
    policy_smallest = 1'b0;
    capacity        = CAP_W'(1);
    tx_idle         = 1'b1;
    rx_idle         = 1'b1;
    hold_request    = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_zero_capacity();
    test_smallest_first_ties();
    test_capacity_lowered();
    test_random_traffic();
    test_output_backpressure();

    wait_drained(FLUSH_CYCLES);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
